[src/lbc_pkg.sv]
// shared types and constants of the led group blink controller
package lbc_pkg;

    localparam int DEF_MAX_LEDS   = 32;
    localparam int DEF_MAX_GROUPS = 4;
    localparam int NUM_MULT_REGS  = 4;

    localparam int LED_FIELD_W  = 32;
    localparam int OPCODE_W     = 4;
    localparam int GIDX_W       = 2;
    localparam int LCOUNT_W     = 6;
    localparam int GCOUNT_W     = 3;
    localparam int MULT_W       = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 32;

    // bit positions inside the slave tdata word
    localparam int TD_MASK_LSB  = 0;
    localparam int TD_LEVEL_BIT = 32;
    localparam int TD_GIDX_LSB  = 33;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ON         = 4'd0,
        OP_OFF        = 4'd1,
        OP_SET_LEVEL  = 4'd2,
        OP_TOGGLE     = 4'd3,
        OP_ALL_ON     = 4'd4,
        OP_ALL_OFF    = 4'd5,
        OP_LOAD       = 4'd6,
        OP_ALL_TOGGLE = 4'd7,
        OP_ATTACH     = 4'd8,
        OP_DETACH     = 4'd9,
        OP_TICK       = 4'd10
    } t_opcode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LED_COUNT   = 3'd0,
        REG_GROUP_COUNT = 3'd1,
        REG_GROUP0_MULT = 3'd2,
        REG_GROUP1_MULT = 3'd3,
        REG_GROUP2_MULT = 3'd4,
        REG_GROUP3_MULT = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [LCOUNT_W-1:0]                  led_count;
        logic [GCOUNT_W-1:0]                  group_count;
        logic [NUM_MULT_REGS-1:0][MULT_W-1:0] multiple;
    } t_cfg;

endpackage

[src/lbc_engine.sv]
// led vector and blink group state with the combinational command logic
module lbc_engine
    import lbc_pkg::*;
#(
    parameter int MAX_LEDS   = DEF_MAX_LEDS,
    parameter int MAX_GROUPS = DEF_MAX_GROUPS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_step,
    input  logic [OPCODE_W-1:0]    i_opcode,
    input  logic [LED_FIELD_W-1:0] i_led_mask,
    input  logic                   i_level,
    input  logic [GIDX_W-1:0]      i_group_index,
    output logic                   o_has_result,
    output logic [LED_FIELD_W-1:0] o_led_state
);

    localparam int NG_W = $clog2(MAX_GROUPS + 1) + 1;

    logic [MAX_LEDS-1:0] r_led;
    logic [MAX_LEDS-1:0] n_led;
    logic [MAX_LEDS-1:0] r_grp_mask [MAX_GROUPS];
    logic [MAX_LEDS-1:0] n_grp_mask [MAX_GROUPS];
    logic                r_grp_phase [MAX_GROUPS];
    logic                n_grp_phase [MAX_GROUPS];
    logic [MULT_W-1:0]   r_grp_cd [MAX_GROUPS];
    logic [MULT_W-1:0]   n_grp_cd [MAX_GROUPS];

    logic [NG_W-1:0]     active_ng;
    logic [MAX_LEDS-1:0] mask;
    logic [MAX_LEDS-1:0] bound;
    logic                gi_ok;
    t_opcode             op;

    // saturate group count, build the led-count bound
    always_comb begin
        if (NG_W'(i_cfg.group_count) > NG_W'(MAX_GROUPS)) begin
            active_ng = NG_W'(MAX_GROUPS);
        end else begin
            active_ng = NG_W'(i_cfg.group_count);
        end
        for (int i = 0; i < MAX_LEDS; i++) begin
            bound[i] = (i < int'(i_cfg.led_count));
        end
    end

    assign mask  = i_led_mask[MAX_LEDS-1:0];
    assign gi_ok = NG_W'(i_group_index) < active_ng;
    assign op    = t_opcode'(i_opcode);

    always_comb begin
        logic [MULT_W-1:0] mult;
        logic              ph;
        logic [MAX_LEDS-1:0] sel;
        n_led        = r_led;
        o_has_result = 1'b1;
        mult         = '0;
        ph           = 1'b0;
        sel          = '0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            n_grp_mask[g]  = r_grp_mask[g];
            n_grp_phase[g] = r_grp_phase[g];
            n_grp_cd[g]    = r_grp_cd[g];
        end
        unique case (op)
            OP_ON:         n_led = r_led | mask;
            OP_OFF:        n_led = r_led & ~mask;
            OP_SET_LEVEL:  n_led = i_level ? (r_led | mask) : (r_led & ~mask);
            OP_TOGGLE:     n_led = r_led ^ mask;
            OP_ALL_ON:     n_led = bound;
            OP_ALL_OFF:    n_led = '0;
            OP_LOAD:       n_led = mask;
            OP_ALL_TOGGLE: n_led = r_led ^ bound;
            OP_ATTACH: begin
                o_has_result = 1'b0;
                if (gi_ok) begin
                    for (int g = 0; g < MAX_GROUPS; g++) begin
                        if (g < int'(active_ng)) begin
                            if (g == int'(i_group_index)) begin
                                n_grp_mask[g] = r_grp_mask[g] | mask;
                            end else begin
                                n_grp_mask[g] = r_grp_mask[g] & ~mask;
                            end
                        end
                    end
                end
            end
            OP_DETACH: begin
                o_has_result = gi_ok;
                if (gi_ok) begin
                    for (int g = 0; g < MAX_GROUPS; g++) begin
                        if (g == int'(i_group_index)) begin
                            n_grp_mask[g] = r_grp_mask[g] & ~mask;
                        end
                    end
                    n_led = i_level ? (r_led | mask) : (r_led & ~mask);
                end
            end
            OP_TICK: begin
                // ascending order: a later group wins on shared leds
                for (int g = 0; g < MAX_GROUPS; g++) begin
                    if (g < int'(active_ng)) begin
                        if (r_grp_cd[g] == '0) begin
                            if (g < NUM_MULT_REGS) begin
                                mult = i_cfg.multiple[g % NUM_MULT_REGS];
                            end else begin
                                mult = MULT_W'(1);
                            end
                            ph             = ~r_grp_phase[g];
                            sel            = r_grp_mask[g] & bound;
                            n_grp_cd[g]    = mult - MULT_W'(1);
                            n_grp_phase[g] = ph;
                            n_led          = ph ? (n_led | sel) : (n_led & ~sel);
                        end else begin
                            n_grp_cd[g] = r_grp_cd[g] - MULT_W'(1);
                        end
                    end
                end
            end
            default:       o_has_result = 1'b0;
        endcase
    end

    assign o_led_state = LED_FIELD_W'(n_led);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led <= '0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_grp_mask[g]  <= '0;
                r_grp_phase[g] <= 1'b0;
                r_grp_cd[g]    <= '0;
            end
        end else if (i_step) begin
            r_led <= n_led;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_grp_mask[g]  <= n_grp_mask[g];
                r_grp_phase[g] <= n_grp_phase[g];
                r_grp_cd[g]    <= n_grp_cd[g];
            end
        end
    end

endmodule

[src/led_group_blink_controller.sv]
// top level of the led group blink controller: config, input and result registers
//
// usage
//   slave stream carries one command per transfer: tuser holds the opcode,
//   tdata holds led_mask, level and group_index
//   master stream carries the led vector after each command that reports one;
//   attach, attach/detach to an inactive group and unused opcodes report nothing
//   config port writes led_count, group_count and the four group multiples
//   by index; the user must write only while no command is in flight, unchecked by the block
// flow and throughput
//   a command is captured in the input register at its transfer, executes
//   from there once the output register is free, and its result is written
//   into the output register; one command per cycle sustained while the
//   result stream is not stalled, set by the state update in the engine
// reset
//   synchronous active-low; led vector, group masks, phases and countdowns
//   clear, led_count 8, group_count 1, every multiple 1
// stalls
//   a held result keeps the output register; the input register still takes
//   one more command, then s_axis_tready drops until the result is taken
module led_group_blink_controller
    import lbc_pkg::*;
#(
    parameter int MAX_LEDS   = DEF_MAX_LEDS,
    parameter int MAX_GROUPS = DEF_MAX_GROUPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // command stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // led_mask[31:0], level[32], group_index[34:33]
    input  logic [OPCODE_W-1:0]   s_axis_tuser,  // opcode[3:0]
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata   // led_state[31:0]
);

    t_cfg r_cfg;

    logic                   r_in_valid;
    logic [OPCODE_W-1:0]    r_in_opcode;
    logic [LED_FIELD_W-1:0] r_in_mask;
    logic                   r_in_level;
    logic [GIDX_W-1:0]      r_in_gidx;

    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;

    logic                   step;
    logic                   has_result;
    logic [LED_FIELD_W-1:0] led_state;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count   <= LCOUNT_W'(8);
            r_cfg.group_count <= GCOUNT_W'(1);
            for (int m = 0; m < NUM_MULT_REGS; m++) begin
                r_cfg.multiple[m] <= MULT_W'(1);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_LED_COUNT:   r_cfg.led_count   <= i_cfg_wdata[LCOUNT_W-1:0];
                REG_GROUP_COUNT: r_cfg.group_count <= i_cfg_wdata[GCOUNT_W-1:0];
                REG_GROUP0_MULT: r_cfg.multiple[0] <= i_cfg_wdata[MULT_W-1:0];
                REG_GROUP1_MULT: r_cfg.multiple[1] <= i_cfg_wdata[MULT_W-1:0];
                REG_GROUP2_MULT: r_cfg.multiple[2] <= i_cfg_wdata[MULT_W-1:0];
                REG_GROUP3_MULT: r_cfg.multiple[3] <= i_cfg_wdata[MULT_W-1:0];
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // execute the held command when the output register can take its result
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_opcode <= s_axis_tuser;
            r_in_mask   <= s_axis_tdata[TD_MASK_LSB +: LED_FIELD_W];
            r_in_level  <= s_axis_tdata[TD_LEVEL_BIT];
            r_in_gidx   <= s_axis_tdata[TD_GIDX_LSB +: GIDX_W];
        end
    end

    lbc_engine #(
        .MAX_LEDS   (MAX_LEDS),
        .MAX_GROUPS (MAX_GROUPS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_step        (step),
        .i_opcode      (r_in_opcode),
        .i_led_mask    (r_in_mask),
        .i_level       (r_in_level),
        .i_group_index (r_in_gidx),
        .o_has_result  (has_result),
        .o_led_state   (led_state)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && has_result) begin
            r_out_data <= M_TDATA_W'(led_state);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
